[sv/iaf_pkg.sv]
// ----------------------------------------------------------------------------
// iaf_pkg
// Shared widths, constants and types of the integrate-and-fire accumulator.
// ----------------------------------------------------------------------------
package iaf_pkg;

  localparam int MAX_FRAME_DIM = 512;
  localparam int IDX_W         = $clog2(MAX_FRAME_DIM);
  localparam int DIM_W         = 10;
  localparam int ALPHA_W       = 16;
  localparam int HID_W         = 16;
  localparam int ACC_W         = 40;
  localparam int SHARE_W       = ALPHA_W + 1;
  localparam int PROD_W        = SHARE_W + 1 + HID_W;
  localparam int REM_W         = ALPHA_W + 1 + HID_W;

  localparam logic [SHARE_W-1:0] ONE_Q16 = SHARE_W'(1) << ALPHA_W;
  localparam logic [DIM_W-1:0]   MAX_DIM = DIM_W'(MAX_FRAME_DIM);

  // One result item as it waits in the output buffer.
  typedef struct packed {
    logic signed [ACC_W-1:0] fired_value;
    logic                    last_of_frame;
  } out_item_t;

  // Saturate a one-bit-grown sum back to the accumulator width.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/iaf_if.sv]
// ----------------------------------------------------------------------------
// iaf_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface iaf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [iaf_pkg::ALPHA_W-1:0]     weight_alpha;
  logic signed [iaf_pkg::HID_W-1:0]       hidden_value;
  logic                                   utterance_start;

  modport source (output valid, weight_alpha, hidden_value, utterance_start, input ready);
  modport sink   (input valid, weight_alpha, hidden_value, utterance_start, output ready);
endinterface

interface iaf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [iaf_pkg::ACC_W-1:0]       fired_value;
  logic                                   last_of_frame;

  modport source (output valid, fired_value, last_of_frame, input ready);
  modport sink   (input valid, fired_value, last_of_frame, output ready);
endinterface

[sv/iaf_out_buf.sv]
// ----------------------------------------------------------------------------
// iaf_out_buf
// Two-entry result buffer that decouples the pipeline from the output side.
// ----------------------------------------------------------------------------
module iaf_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  iaf_pkg::out_item_t  push_item,
  input  logic                pop,
  output logic                head_valid,
  output iaf_pkg::out_item_t  head_item,
  output logic [1:0]          count
);

  iaf_pkg::out_item_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_valid = (count_r != 2'd0);
  assign head_item  = slot_r[rd_ptr_r];
  assign count      = count_r;

endmodule

[sv/integrate_and_fire_frame_accumulator.sv]
// ----------------------------------------------------------------------------
// integrate_and_fire_frame_accumulator
// Continuous integrate-and-fire over streamed frame elements.
// ----------------------------------------------------------------------------
// Only a fired item gives a result; it passes stage 1 and the result buffer.
// Throughput: one item per cycle while no clearing pass runs and the result
// buffer has room, set by the single read-modify-write of the accumulator
// memory (one read port, one write port, forwarding between them).
// Reset: synchronous, active low. After reset a clearing pass writes zero to
// all 512 accumulator entries, one per cycle; no item is taken while it runs.
// Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module integrate_and_fire_frame_accumulator (
  input  logic                          clk,
  input  logic                          rst_n,
  iaf_in_if.sink                        in_ch,
  iaf_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [iaf_pkg::DIM_W-1:0]     cfg_wdata
);

  localparam int IDX_W   = iaf_pkg::IDX_W;
  localparam int ACC_W   = iaf_pkg::ACC_W;
  localparam int PROD_W  = iaf_pkg::PROD_W;
  localparam int REM_W   = iaf_pkg::REM_W;
  localparam int SHARE_W = iaf_pkg::SHARE_W;
  localparam int ALPHA_W = iaf_pkg::ALPHA_W;

  // ---------------------------------------------------------------- config
  logic [iaf_pkg::DIM_W-1:0] dim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= iaf_pkg::MAX_DIM;
    end else if (cfg_we) begin
      dim_r <= cfg_wdata;
    end
  end

  // The frame length is clamped to 1..MAX_FRAME_DIM; the index of the last
  // element is therefore always representable in IDX_W bits.
  logic [IDX_W-1:0] last_idx;
  always_comb begin
    if (dim_r == '0) begin
      last_idx = '0;
    end else if (dim_r > iaf_pkg::MAX_DIM) begin
      last_idx = IDX_W'(iaf_pkg::MAX_FRAME_DIM - 1);
    end else begin
      last_idx = IDX_W'(dim_r - 1'b1);
    end
  end

  // ---------------------------------------------------------- clearing pass
  logic             clr_busy_r, clr_busy_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;

  always_comb begin
    clr_idx_nxt  = clr_idx_r + 1'b1;
    clr_busy_nxt = clr_busy_r && (clr_idx_r != IDX_W'(iaf_pkg::MAX_FRAME_DIM - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  // ------------------------------------------------------- stage 0: accept
  // Integral and element counter live in registers, updated at acceptance
  // (the integral only on a frame's last element), so the next item sees
  // them at once. The two products (completion share, or alpha without a
  // fire, and remainder share, times hidden value) are formed and registered.
  logic             in_acc;
  logic [1:0]       buf_count;
  logic             buf_pop;
  logic             s1_valid_r;
  logic             s1_fire_r;

  logic [ALPHA_W-1:0] integral_r;
  logic [IDX_W-1:0]   elem_cnt_r;

  logic [IDX_W-1:0]   s0_idx;
  logic               s0_last;
  logic [ALPHA_W-1:0] s0_integ;
  logic [SHARE_W-1:0] s0_sum;
  logic               s0_fire;
  logic [SHARE_W-1:0] s0_share;
  logic [ALPHA_W-1:0] s0_rem;
  logic [2:0]         occupancy;

  // Room check: results in the buffer after this edge plus the one still in
  // stage 1 must leave a slot for the item accepted now.
  always_comb begin
    occupancy   = 3'(buf_count) + 3'(s1_valid_r && s1_fire_r) - 3'(buf_pop);
    in_ch.ready = !clr_busy_r && (occupancy <= 3'd1);
  end
  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    if (elem_cnt_r >= last_idx) begin
      s0_idx  = last_idx;
      s0_last = 1'b1;
    end else begin
      s0_idx  = elem_cnt_r;
      s0_last = 1'b0;
    end
    s0_integ = in_ch.utterance_start ? '0 : integral_r;
    s0_sum   = {1'b0, s0_integ} + {1'b0, in_ch.weight_alpha};
    s0_fire  = s0_sum[ALPHA_W];
    s0_share = s0_fire ? (iaf_pkg::ONE_Q16 - {1'b0, s0_integ}) : {1'b0, in_ch.weight_alpha};
    // On a fire, alpha minus the completion share equals the sum minus one.
    s0_rem   = s0_fire ? s0_sum[ALPHA_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      elem_cnt_r <= '0;
    end else if (in_acc) begin
      if (s0_last) begin
        // Whether or not it fired, the new integral is the low 16 bits of the sum.
        integral_r <= s0_sum[ALPHA_W-1:0];
        elem_cnt_r <= '0;
      end else begin
        elem_cnt_r <= s0_idx + 1'b1;
      end
    end
  end

  // Stage 1 registers.
  logic                     s1_last_r;
  logic                     s1_start_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic signed [PROD_W-1:0] s1_prod_r;
  logic signed [REM_W-1:0]  s1_rem_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_fire_r     <= s0_fire;
      s1_last_r     <= s0_last;
      s1_start_r    <= in_ch.utterance_start;
      s1_idx_r      <= s0_idx;
      s1_prod_r     <= PROD_W'($signed({1'b0, s0_share}) * in_ch.hidden_value);
      s1_rem_prod_r <= REM_W'($signed({1'b0, s0_rem}) * in_ch.hidden_value);
    end
  end

  // ------------------------------------------------- accumulator memory
  // One synchronous read per cycle at the stage-0 index, one write per cycle
  // from stage 1 or from the clearing pass.
  logic signed [ACC_W-1:0] acc_mem [iaf_pkg::MAX_FRAME_DIM];
  logic signed [ACC_W-1:0] mem_rd_r;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic signed [ACC_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      acc_mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_r <= acc_mem[s0_idx];
  end

  // ------------------------------------------------ stage 1: modify, write
  // The memory read returns the old value when stage 1 is writing the same
  // entry in that cycle (frame length of one), so the last written value is
  // kept and forwarded on an address match.
  logic                    fwd_valid_r;
  logic [IDX_W-1:0]        fwd_idx_r;
  logic signed [ACC_W-1:0] fwd_data_r;

  logic signed [ACC_W-1:0] s1_base;
  logic signed [ACC_W:0]   s1_sum;
  logic signed [ACC_W-1:0] s1_acc;

  always_comb begin
    if (s1_start_r) begin
      s1_base = '0;
    end else if (fwd_valid_r && (fwd_idx_r == s1_idx_r)) begin
      s1_base = fwd_data_r;
    end else begin
      s1_base = mem_rd_r;
    end
    s1_sum = {s1_base[ACC_W-1], s1_base} + (ACC_W+1)'(s1_prod_r);
    s1_acc = iaf_pkg::sat_acc(s1_sum);
  end

  always_comb begin
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_valid_r;
      mem_waddr = s1_idx_r;
      // After a fire the entry restarts with the remainder share.
      mem_wdata = s1_fire_r ? ACC_W'(s1_rem_prod_r) : s1_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (s1_valid_r && !clr_busy_r) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && !clr_busy_r) begin
      fwd_idx_r  <= s1_idx_r;
      fwd_data_r <= mem_wdata;
    end
  end

  // ------------------------------------------------------- result buffer
  iaf_pkg::out_item_t push_item;
  iaf_pkg::out_item_t head_item;
  logic               head_valid;

  always_comb begin
    push_item.fired_value   = s1_acc;
    push_item.last_of_frame = s1_last_r;
  end

  assign buf_pop = head_valid && out_ch.ready;

  iaf_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_valid_r && s1_fire_r),
    .push_item  (push_item),
    .pop        (buf_pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (buf_count)
  );

  assign out_ch.valid         = head_valid;
  assign out_ch.fired_value   = head_item.fired_value;
  assign out_ch.last_of_frame = head_item.last_of_frame;

endmodule
